// ===== sv/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16BE to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int UNIT_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int MAX_BYTES   = 4;
    localparam int IDX_W       = $clog2(MAX_BYTES);
    localparam int LOW10_W     = 10;
    localparam int CP_W        = 21;

    // Job queue between front and back
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_AW + 1;

    // Byte-order mark in UTF-8
    localparam logic [BYTE_W-1:0] BOM_B0 = 8'hEF;
    localparam logic [BYTE_W-1:0] BOM_B1 = 8'hBB;
    localparam logic [BYTE_W-1:0] BOM_B2 = 8'hBF;

    // High surrogate D800..DBFF: top six bits 110110
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;

    // Lead / continuation byte prefixes
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Byte counts expressed as index of the last byte
    localparam logic [IDX_W-1:0] LAST_1B = 2'd0;
    localparam logic [IDX_W-1:0] LAST_2B = 2'd1;
    localparam logic [IDX_W-1:0] LAST_3B = 2'd2;
    localparam logic [IDX_W-1:0] LAST_4B = 2'd3;

    // One encoded character: bytes[0] goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]                 last_idx;
    } t_job;

endpackage

// ===== sv/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks surrogate pairing and builds encoded jobs.
// ----------------------------------------------------------------------------
module u16u8_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [u16u8_pkg::UNIT_W-1:0]   i_code_unit,
    input  logic                           i_stream_start,
    output logic                           o_job_push,
    output u16u8_pkg::t_job                o_job
);

    logic                              r_high_pending;
    logic [u16u8_pkg::LOW10_W-1:0]     r_held_high;
    logic                              n_high_pending;
    logic [u16u8_pkg::LOW10_W-1:0]     n_held_high;

    logic                              is_high_surr;
    logic [u16u8_pkg::CP_W-1:0]        pair_cp;
    logic [u16u8_pkg::UNIT_W-1:0]      u;

    assign u            = i_code_unit;
    assign is_high_surr = (u[15:10] == u16u8_pkg::HI_SURR_TAG);
    assign pair_cp      = u16u8_pkg::CP_W'(21'h10000)
                        + {1'b0, r_held_high, u[9:0]};

    always_comb begin
        n_high_pending = r_high_pending;
        n_held_high    = r_held_high;
        o_job_push     = 1'b0;
        o_job          = '0;
        if (i_stream_start) begin
            o_job_push     = i_accept;
            o_job.bytes[0] = u16u8_pkg::BOM_B0;
            o_job.bytes[1] = u16u8_pkg::BOM_B1;
            o_job.bytes[2] = u16u8_pkg::BOM_B2;
            o_job.last_idx = u16u8_pkg::LAST_3B;
            if (i_accept) begin
                n_high_pending = 1'b0;
                n_held_high    = '0;
            end
        end else if (r_high_pending) begin
            // Pair always yields a supplementary code point: four bytes
            o_job_push     = i_accept;
            o_job.bytes[0] = {u16u8_pkg::LEAD4_TAG, pair_cp[20:18]};
            o_job.bytes[1] = {u16u8_pkg::CONT_TAG, pair_cp[17:12]};
            o_job.bytes[2] = {u16u8_pkg::CONT_TAG, pair_cp[11:6]};
            o_job.bytes[3] = {u16u8_pkg::CONT_TAG, pair_cp[5:0]};
            o_job.last_idx = u16u8_pkg::LAST_4B;
            if (i_accept) begin
                n_high_pending = 1'b0;
                n_held_high    = '0;
            end
        end else if (is_high_surr) begin
            if (i_accept) begin
                n_high_pending = 1'b1;
                n_held_high    = u[9:0];
            end
        end else begin
            o_job_push = i_accept;
            if (u[15:7] == '0) begin
                o_job.bytes[0] = {1'b0, u[6:0]};
                o_job.last_idx = u16u8_pkg::LAST_1B;
            end else if (u[15:11] == '0) begin
                o_job.bytes[0] = {u16u8_pkg::LEAD2_TAG, u[10:6]};
                o_job.bytes[1] = {u16u8_pkg::CONT_TAG, u[5:0]};
                o_job.last_idx = u16u8_pkg::LAST_2B;
            end else begin
                o_job.bytes[0] = {u16u8_pkg::LEAD3_TAG, u[15:12]};
                o_job.bytes[1] = {u16u8_pkg::CONT_TAG, u[11:6]};
                o_job.bytes[2] = {u16u8_pkg::CONT_TAG, u[5:0]};
                o_job.last_idx = u16u8_pkg::LAST_3B;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_pending <= 1'b0;
            r_held_high    <= '0;
        end else begin
            r_high_pending <= n_high_pending;
            r_held_high    <= n_held_high;
        end
    end

endmodule

// ===== sv/u16u8_fifo.sv =====
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short job queue decoupling the front end from the byte serializer.
// ----------------------------------------------------------------------------
module u16u8_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u16u8_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output u16u8_pkg::t_job o_job
);

    u16u8_pkg::t_job                         r_mem [u16u8_pkg::FIFO_DEPTH];
    logic [u16u8_pkg::FIFO_AW-1:0]           r_wr_ptr;
    logic [u16u8_pkg::FIFO_AW-1:0]           r_rd_ptr;
    logic [u16u8_pkg::FIFO_CNT_W-1:0]        r_count;
    logic                                    do_push;
    logic                                    do_pop;

    assign o_full  = (r_count == u16u8_pkg::FIFO_CNT_W'(u16u8_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes queued jobs into one UTF-8 byte per transaction.
// ----------------------------------------------------------------------------
module u16u8_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_empty,
    input  u16u8_pkg::t_job                i_job,
    output logic                           o_job_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic [u16u8_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                           o_last_of_run
);

    logic                                  r_busy;
    u16u8_pkg::t_job                       r_job;
    logic [u16u8_pkg::IDX_W-1:0]           r_idx;
    logic                                  r_out_valid;
    logic [u16u8_pkg::BYTE_W-1:0]          r_out_byte;
    logic                                  r_out_last;

    logic                                  advance;
    logic                                  emit;
    logic                                  at_last;

    assign advance   = !r_out_valid || pop;
    assign emit      = r_busy && advance;
    assign at_last   = (r_idx == r_job.last_idx);
    assign o_job_pop = !i_job_empty && (!r_busy || (emit && at_last));

    assign empty         = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out_byte <= r_job.bytes[r_idx];
            r_out_last <= at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/utf16be_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16be_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, one byte per output transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one 16-bit code unit (big-endian bytes already
// combined). Output transactions carry one UTF-8 byte each; o_last_of_run
// flags the final byte caused by an input unit. A unit flagged stream_start is
// dropped and replaced by the UTF-8 byte-order mark EF BB BF, and it discards
// any held high surrogate. A high surrogate produces no output and is paired
// with whatever unit comes next (only its low 10 bits are used), giving four
// bytes. Any other unit is encoded directly as one to three bytes; no
// validation is done. Throughput: the output side moves one byte per cycle while
// jobs are queued and the receiver pops; a held high surrogate gives no bytes.
// The byte serializer sets that rate. The input side takes a new unit every
// cycle while the two-entry job queue has room; units back up there when
// characters outrun the serializer or the receiver stalls. An accepted unit
// passes the job queue, the job register and the registered output stage.
// ----------------------------------------------------------------------------
module utf16be_to_utf8_transcoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input queue side
    input  logic                           push,
    output logic                           full,
    input  logic [u16u8_pkg::UNIT_W-1:0]   i_code_unit,
    input  logic                           i_stream_start,
    // result queue side
    input  logic                           pop,
    output logic                           empty,
    output logic [u16u8_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                           o_last_of_run
);

    logic            accept;
    logic            job_push;
    u16u8_pkg::t_job front_job;
    logic            job_pop;
    logic            job_empty;
    u16u8_pkg::t_job queued_job;

    // Input is held off only by a full job queue.
    assign accept = push && !full;

    // Front: pairing state and encoding into a job of up to four bytes.
    u16u8_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_code_unit    (i_code_unit),
        .i_stream_start (i_stream_start),
        .o_job_push     (job_push),
        .o_job          (front_job)
    );

    // Job queue: lets the front keep taking units while the back drains bytes.
    u16u8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_job   (queued_job)
    );

    // Back: walks the bytes of each job into the registered output stage.
    u16u8_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (job_empty),
        .i_job         (queued_job),
        .o_job_pop     (job_pop),
        .pop           (pop),
        .empty         (empty),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-16BE to UTF-8 transcoder.
// ----------------------------------------------------------------------------
// A clocked driver feeds code units from a queue of pending units. The
// initial block fills that queue phase by phase. Each accepted unit runs
// through a bit-level predictor of the transcoder, which appends the expected
// UTF-8 bytes to a queue. A clocked monitor compares every accepted byte with
// the oldest expected byte. Phases vary sender gaps and receiver stalls. Each
// phase ends with the sender holding off until every expected byte has come.
// A watchdog ends the run when no transaction moves for too long.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT = 4000;   // cycles with work but no transaction
    localparam int DRAIN_CYCLES = 20;    // settle time after the last byte
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [u16u8_pkg::UNIT_W-1:0] unit;
        logic                         start;
    } t_unit_item;

    typedef struct packed {
        logic [u16u8_pkg::BYTE_W-1:0] data;
        logic                         last;
    } t_utf8_byte;

    // ------------------------------------------------------------------------
    // DUT signals; the driven inputs are known from time zero
    // ------------------------------------------------------------------------
    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    logic [u16u8_pkg::UNIT_W-1:0] i_code_unit = '0;
    logic                         i_stream_start = 1'b0;
    logic                         pop = 1'b0;
    logic                         empty;
    logic [u16u8_pkg::BYTE_W-1:0] o_out_byte;
    logic                         o_last_of_run;

    utf16be_to_utf8_transcoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_code_unit    (i_code_unit),
        .i_stream_start (i_stream_start),
        .pop            (pop),
        .empty          (empty),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_unit_item units_pending[$];      // units still to be sent
    t_utf8_byte utf8_expected[$];      // bytes the transcoder still owes us

    // predictor copy of the transcoder state
    logic [u16u8_pkg::LOW10_W-1:0] pred_held_high;
    logic                          pred_high_pending;

    // idling percentages, changed by the phase sequencer on falling edges
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned units_sent = 0;
    int unsigned bytes_checked = 0;
    int unsigned pairs_seen = 0;
    int unsigned marks_seen = 0;
    int unsigned mismatches = 0;
    int unsigned stall_count = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void owe_byte(input logic [u16u8_pkg::BYTE_W-1:0] data,
                                     input logic last);
        t_utf8_byte b;
        b.data = data;
        b.last = last;
        utf8_expected.push_back(b);
    endfunction

    function automatic void owe_code_point(input logic [u16u8_pkg::CP_W-1:0] cp);
        if (cp < 21'h80) begin
            owe_byte(cp[7:0], 1'b1);
        end else if (cp < 21'h800) begin
            owe_byte({u16u8_pkg::LEAD2_TAG, cp[10:6]}, 1'b0);
            owe_byte({u16u8_pkg::CONT_TAG, cp[5:0]}, 1'b1);
        end else if (cp < 21'h10000) begin
            owe_byte({u16u8_pkg::LEAD3_TAG, cp[15:12]}, 1'b0);
            owe_byte({u16u8_pkg::CONT_TAG, cp[11:6]}, 1'b0);
            owe_byte({u16u8_pkg::CONT_TAG, cp[5:0]}, 1'b1);
        end else begin
            owe_byte({u16u8_pkg::LEAD4_TAG, cp[20:18]}, 1'b0);
            owe_byte({u16u8_pkg::CONT_TAG, cp[17:12]}, 1'b0);
            owe_byte({u16u8_pkg::CONT_TAG, cp[11:6]}, 1'b0);
            owe_byte({u16u8_pkg::CONT_TAG, cp[5:0]}, 1'b1);
        end
    endfunction

    function automatic void transcode_unit(input logic [u16u8_pkg::UNIT_W-1:0] unit,
                                           input logic start);
        logic [u16u8_pkg::CP_W-1:0] cp;
        if (start) begin
            // mark replaces the unit and flushes any held high half
            pred_high_pending = 1'b0;
            pred_held_high = '0;
            marks_seen++;
            owe_byte(u16u8_pkg::BOM_B0, 1'b0);
            owe_byte(u16u8_pkg::BOM_B1, 1'b0);
            owe_byte(u16u8_pkg::BOM_B2, 1'b1);
        end else if (pred_high_pending) begin
            // whatever follows a high half is its low half, low 10 bits only
            cp = 21'h10000 + {1'b0, pred_held_high, unit[u16u8_pkg::LOW10_W-1:0]};
            pred_high_pending = 1'b0;
            pred_held_high = '0;
            pairs_seen++;
            owe_code_point(cp);
        end else if (unit[15:10] == u16u8_pkg::HI_SURR_TAG) begin
            pred_held_high = unit[u16u8_pkg::LOW10_W-1:0];
            pred_high_pending = 1'b1;
        end else begin
            owe_code_point({5'd0, unit});
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents the head of the pending queue, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                transcode_unit(i_code_unit, i_stream_start);
                units_sent++;
                void'(units_pending.pop_front());
            end
            if (push && full) begin
                // blocked: hold the unit in place
            end else if (units_pending.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                push           <= 1'b1;
                i_code_unit    <= units_pending[0].unit;
                i_stream_start <= units_pending[0].start;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted byte against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_utf8_byte want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (utf8_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected byte %02h last=%0b", $realtime,
                                 o_out_byte, o_last_of_run);
                end else begin
                    want = utf8_expected.pop_front();
                    bytes_checked++;
                    if (o_out_byte !== want.data || o_last_of_run !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: byte mismatch: expected %02h last=%0b, ",
                                      "got %02h last=%0b"},
                                     $realtime, want.data, want.last, o_out_byte,
                                     o_last_of_run);
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: only counts while work is outstanding
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && (units_pending.size() != 0 || utf8_expected.size() != 0)) begin
            if ((push && !full) || (pop && !empty)) begin
                stall_count = 0;
            end else begin
                stall_count++;
                if (stall_count >= STALL_LIMIT) begin
                    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                    $display("testbench failed");
                    $finish;
                end
            end
        end else begin
            stall_count = 0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void queue_unit(input logic [u16u8_pkg::UNIT_W-1:0] unit,
                                       input logic start);
        t_unit_item it;
        it.unit = unit;
        it.start = start;
        units_pending.push_back(it);
    endfunction

    // One random character, mostly well formed; returns how many units queued.
    function automatic int queue_random_char();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            queue_unit(16'($urandom_range(16'h007F)), 1'b0);
        end else if (sel < 30) begin
            queue_unit(16'($urandom_range(16'h07FF, 16'h0080)), 1'b0);
        end else if (sel < 50) begin
            // BMP outside the surrogate range
            if ($urandom_range(1))
                queue_unit(16'($urandom_range(16'hD7FF, 16'h0800)), 1'b0);
            else
                queue_unit(16'($urandom_range(16'hFFFF, 16'hE000)), 1'b0);
        end else if (sel < 75) begin
            // proper surrogate pair
            queue_unit(16'(16'hD800 + $urandom_range(1023)), 1'b0);
            queue_unit(16'(16'hDC00 + $urandom_range(1023)), 1'b0);
            return 2;
        end else if (sel < 80) begin
            // stream mark, usually FEFF, sometimes junk
            queue_unit($urandom_range(3) != 0 ? 16'hFEFF : 16'($urandom), 1'b1);
        end else if (sel < 85) begin
            // high half followed by anything, mark included
            queue_unit(16'(16'hD800 + $urandom_range(1023)), 1'b0);
            queue_unit(16'($urandom), ($urandom_range(7) == 0));
            return 2;
        end else if (sel < 90) begin
            queue_unit(16'(16'hDC00 + $urandom_range(1023)), 1'b0);
        end else begin
            queue_unit(16'($urandom), 1'b0);
        end
        return 1;
    endfunction

    // Sets idling, sends a batch, then holds off until every byte has come.
    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int n_units);
        int queued;
        queued = 0;
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        while (queued < n_units)
            queued += queue_random_char();
        while (units_pending.size() != 0 || utf8_expected.size() != 0 || push)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        pred_held_high = '0;
        pred_high_pending = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: encoding boundaries, marks and surrogate corner cases
        queue_unit(16'h0000, 1'b0);
        queue_unit(16'h007F, 1'b0);
        queue_unit(16'h0080, 1'b0);
        queue_unit(16'h07FF, 1'b0);
        queue_unit(16'h0800, 1'b0);
        queue_unit(16'hD7FF, 1'b0);
        queue_unit(16'hE000, 1'b0);
        queue_unit(16'hFFFF, 1'b0);
        queue_unit(16'hFEFF, 1'b1);
        queue_unit(16'h1234, 1'b1);      // mark on a non-FEFF unit
        queue_unit(16'hFFFF, 1'b1);
        queue_unit(16'hD800, 1'b0);      // lowest pair
        queue_unit(16'hDC00, 1'b0);
        queue_unit(16'hDBFF, 1'b0);      // highest pair
        queue_unit(16'hDFFF, 1'b0);
        queue_unit(16'hD834, 1'b0);      // high half, then a plain letter
        queue_unit(16'h0041, 1'b0);
        queue_unit(16'hDBFF, 1'b0);      // high half dropped by a mark
        queue_unit(16'h0000, 1'b1);
        queue_unit(16'hDC00, 1'b0);      // lone low halves
        queue_unit(16'hDFFF, 1'b0);
        queue_unit(16'hD800, 1'b0);      // high half, then another high half
        queue_unit(16'hD801, 1'b0);
        queue_unit(16'hD9AB, 1'b0);      // high half, then FEFF as a mark
        queue_unit(16'hFEFF, 1'b1);

        run_phase(0, 0, 45);
        run_phase(88, 0, 45);
        run_phase(0, 88, 45);
        run_phase(25, 25, 45);
        run_phase(0, 0, 45);

        if (utf8_expected.size() != 0) begin
            mismatches++;
            $display("%0d expected bytes never arrived", utf8_expected.size());
        end
        $display("covered %0d code units: %0d surrogate pairs, %0d stream marks, %0d bytes",
                 units_sent, pairs_seen, marks_seen, bytes_checked);
        $display("idling phases: none, sender gaps, receiver stalls, both; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
